[design/svpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_pkg
// Shared types and constants of the space vector PWM duty pipeline.
// ----------------------------------------------------------------------------
package svpd_pkg;

    // angle word width; bits 15:14 give the quadrant
    localparam int ANGLE_BITS          = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int COUNT_BITS          = 16;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam logic [16:0] SQRT3_Q16    = 17'd113512;
    localparam logic [15:0] DUTY_MAX_Q16 = 16'd58982;
    localparam logic [15:0] PWM_PERIOD_RESET = 16'd1000;

    // compare count cap, 2^COUNT_BITS - 1 seen through a 16-bit port
    localparam int COUNT_CAP_BITS = (COUNT_BITS < 16) ? COUNT_BITS : 16;
    localparam logic [15:0] COUNT_CAP = 16'((32'd1 << COUNT_CAP_BITS) - 32'd1);

    // sector from {beta > 0, steep, alpha > 0}
    localparam logic [2:0] SECTOR_OF_K [8] = '{
        3'd4, 3'd6, 3'd5, 3'd5, 3'd3, 3'd1, 3'd2, 3'd2
    };

    // sin and cos of k * 60 degrees, Q2.16
    localparam logic signed [17:0] SIN60K [7] = '{
        18'sd0, 18'sd56756, 18'sd56756, 18'sd0, -18'sd56756, -18'sd56756, 18'sd0
    };
    localparam logic signed [17:0] COS60K [7] = '{
        18'sd65536, 18'sd32768, -18'sd32768, -18'sd65536, -18'sd32768, 18'sd32768,
        18'sd65536
    };

    // switching vectors, bit 0 = U, bit 1 = V, bit 2 = W
    localparam logic [2:0] SWITCH_VEC [6] = '{
        3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b101
    };

    typedef struct packed {
        logic [16:0]        sin_mag;
        logic [16:0]        cos_mag;
        logic               sin_neg;
        logic               cos_neg;
        logic signed [15:0] volt_d;
        logic signed [15:0] volt_q;
    } t_trig;

    typedef struct packed {
        logic signed [18:0] alpha;
        logic signed [18:0] beta;
    } t_ab;

    typedef struct packed {
        logic [2:0][15:0] duty;
        logic [2:0]       sector;
    } t_duty;

endpackage

[design/space_vector_pwm_duty.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// space_vector_pwm_duty
// Inverse Park transform and space vector PWM compare count generator.
// ----------------------------------------------------------------------------
// Takes one item (rotor angle, d/q voltage command) per clock and returns the
// three phase compare counts and the sector. Every step is a pipeline stage
// with its own multipliers and the sine/cosine table RAM has two read ports,
// so throughput is one item per cycle; a stalled output holds the pipeline
// only where stages are full. After reset the block loads the sine table
// (2^SINE_TABLE_BITS + 1 entries, one per cycle) and keeps o_in_ready low
// until the last entry has been written.
// pwm_period may be written at any time the block holds no item; it resets
// to 1000.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty #(
    parameter int SINE_TABLE_BITS = svpd_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_rotor_angle,
    input  logic signed [15:0] i_volt_d,
    input  logic signed [15:0] i_volt_q,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_compare_u,
    output logic [15:0]        o_compare_v,
    output logic [15:0]        o_compare_w,
    output logic [2:0]         o_sector_num,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_pwm_period
);

    import svpd_pkg::*;

    logic [15:0] r_pwm_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= PWM_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_pwm_period <= i_cfg_pwm_period;
        end
    end

    assign o_cfg_ready = 1'b1;

    t_trig w_trig;
    logic  w_trig_valid;
    logic  w_trig_ready;
    t_ab   w_ab;
    logic  w_ab_valid;
    logic  w_ab_ready;
    t_duty w_duty;
    logic  w_duty_valid;
    logic  w_duty_ready;

    svpd_sine #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_rotor_angle (i_rotor_angle),
        .i_volt_d      (i_volt_d),
        .i_volt_q      (i_volt_q),
        .o_valid       (w_trig_valid),
        .i_ready       (w_trig_ready),
        .o_trig        (w_trig)
    );

    svpd_park u_park (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_trig_valid),
        .o_ready (w_trig_ready),
        .i_trig  (w_trig),
        .o_valid (w_ab_valid),
        .i_ready (w_ab_ready),
        .o_ab    (w_ab)
    );

    svpd_svm u_svm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ab_valid),
        .o_ready (w_ab_ready),
        .i_ab    (w_ab),
        .o_valid (w_duty_valid),
        .i_ready (w_duty_ready),
        .o_duty  (w_duty)
    );

    svpd_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_duty_valid),
        .o_ready      (w_duty_ready),
        .i_duty       (w_duty),
        .i_period     (r_pwm_period),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_compare_u  (o_compare_u),
        .o_compare_v  (o_compare_v),
        .o_compare_w  (o_compare_w),
        .o_sector_num (o_sector_num)
    );

endmodule

[design/svpd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_ram
// Generic RAM: one write port, two read ports with registered data.
// ----------------------------------------------------------------------------
module svpd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_rd_en) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[design/svpd_sine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_sine
// Quarter-wave sine and cosine lookup. The table RAM is loaded after reset.
// ----------------------------------------------------------------------------
module svpd_sine #(
    parameter int SINE_TABLE_BITS = svpd_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [15:0]         i_rotor_angle,
    input  logic signed [15:0]  i_volt_d,
    input  logic signed [15:0]  i_volt_q,
    output logic                o_valid,
    input  logic                i_ready,
    output svpd_pkg::t_trig     o_trig
);

    import svpd_pkg::*;

    localparam int DEPTH = (1 << SINE_TABLE_BITS) + 1;
    localparam int IW    = SINE_TABLE_BITS + 1;
    localparam int SH    = ANGLE_BITS - 2 - SINE_TABLE_BITS;
    localparam logic [IW-1:0] IDX_FULL = {1'b1, {SINE_TABLE_BITS{1'b0}}};
    localparam longint unsigned TAYLOR_DIV [8] = '{
        64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    // sin of idx quarter steps: odd Taylor series to x^15 in Q2.30, then Q2.16
    function automatic logic [16:0] f_quarter_entry(input int unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        x    = (HALF_PI_Q30 * longint'(idx)) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if ((k & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + 64'sd8192) >>> 14;
        if (sum > 64'sd65536) begin
            sum = 64'sd65536;
        end
        return 17'(sum);
    endfunction

    logic [16:0] w_tab [DEPTH];

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_tab
        assign w_tab[gi] = f_quarter_entry(gi);
    end

    // table load after reset
    logic          r_busy;
    logic          r_fill_run;
    logic [IW-1:0] r_fill_idx;
    logic          r_wr_en;
    logic [IW-1:0] r_wr_addr;
    logic [16:0]   r_wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_fill_run <= 1'b1;
            r_fill_idx <= '0;
            r_wr_en    <= 1'b0;
        end else begin
            r_wr_en <= r_fill_run;
            if (r_fill_run) begin
                if (r_fill_idx == IDX_FULL) begin
                    r_fill_run <= 1'b0;
                end else begin
                    r_fill_idx <= r_fill_idx + 1'b1;
                end
            end
            if (r_wr_en && (r_wr_addr == IDX_FULL)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= r_fill_idx;
        r_wr_data <= w_tab[r_fill_idx];
    end

    // table index of sine and of cosine (a quarter turn ahead)
    logic [1:0]                 w_quad_s;
    logic [1:0]                 w_quad_c;
    logic [SINE_TABLE_BITS-1:0] w_step;
    logic [IW-1:0]              w_idx_s;
    logic [IW-1:0]              w_idx_c;

    assign w_quad_s = i_rotor_angle[ANGLE_BITS-1 -: 2];
    assign w_quad_c = w_quad_s + 2'd1;
    assign w_step   = SINE_TABLE_BITS'(i_rotor_angle[ANGLE_BITS-3:0] >> SH);
    assign w_idx_s  = w_quad_s[0] ? (IDX_FULL - {1'b0, w_step}) : {1'b0, w_step};
    assign w_idx_c  = w_quad_c[0] ? (IDX_FULL - {1'b0, w_step}) : {1'b0, w_step};

    logic              w_en;
    logic              r_v;
    logic              r_sin_neg;
    logic              r_cos_neg;
    logic signed [15:0] r_volt_d;
    logic signed [15:0] r_volt_q;
    logic [16:0]       w_sin_mag;
    logic [16:0]       w_cos_mag;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sin_neg <= w_quad_s[1];
            r_cos_neg <= w_quad_c[1];
            r_volt_d  <= i_volt_d;
            r_volt_q  <= i_volt_q;
        end
    end

    svpd_ram #(
        .WIDTH (17),
        .DEPTH (DEPTH)
    ) u_tab_ram (
        .i_clk     (i_clk),
        .i_we      (r_wr_en),
        .i_waddr   (r_wr_addr),
        .i_wdata   (r_wr_data),
        .i_rd_en   (w_en),
        .i_raddr_a (w_idx_s),
        .i_raddr_b (w_idx_c),
        .o_rdata_a (w_sin_mag),
        .o_rdata_b (w_cos_mag)
    );

    assign o_valid        = r_v;
    assign o_trig.sin_mag = w_sin_mag;
    assign o_trig.cos_mag = w_cos_mag;
    assign o_trig.sin_neg = r_sin_neg;
    assign o_trig.cos_neg = r_cos_neg;
    assign o_trig.volt_d  = r_volt_d;
    assign o_trig.volt_q  = r_volt_q;

    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |=> !r_busy)
        else $error("table load restarted after completion");

    a_no_item_during_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_v)
        else $error("item entered while table was loading");

endmodule

[design/svpd_park.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_park
// Inverse Park transform: rotate the d/q command into alpha/beta.
// ----------------------------------------------------------------------------
module svpd_park (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  svpd_pkg::t_trig i_trig,
    output logic            o_valid,
    input  logic            i_ready,
    output svpd_pkg::t_ab   o_ab
);

    import svpd_pkg::*;

    logic w_en1;
    logic w_en2;
    logic r_v1;
    logic r_v2;

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // stage 1: signed sine/cosine and the four products
    logic signed [17:0] w_sin_pos;
    logic signed [17:0] w_cos_pos;
    logic signed [17:0] w_sin;
    logic signed [17:0] w_cos;
    logic signed [15:0] w_d;
    logic signed [15:0] w_q;
    logic signed [33:0] r1_dc;
    logic signed [33:0] r1_qs;
    logic signed [33:0] r1_ds;
    logic signed [33:0] r1_qc;

    assign w_sin_pos = signed'({1'b0, i_trig.sin_mag});
    assign w_cos_pos = signed'({1'b0, i_trig.cos_mag});
    assign w_sin     = i_trig.sin_neg ? -w_sin_pos : w_sin_pos;
    assign w_cos     = i_trig.cos_neg ? -w_cos_pos : w_cos_pos;
    assign w_d       = i_trig.volt_d;
    assign w_q       = i_trig.volt_q;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_dc <= w_d * w_cos;
            r1_qs <= w_q * w_sin;
            r1_ds <= w_d * w_sin;
            r1_qc <= w_q * w_cos;
        end
    end

    // stage 2: sum and round to Q2.16
    logic signed [34:0] w_sum_a;
    logic signed [34:0] w_sum_b;
    logic signed [18:0] r2_alpha;
    logic signed [18:0] r2_beta;

    assign w_sum_a = 35'(r1_dc) - 35'(r1_qs) + 35'sd16384;
    assign w_sum_b = 35'(r1_ds) + 35'(r1_qc) + 35'sd16384;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_alpha <= 19'(w_sum_a >>> 15);
            r2_beta  <= 19'(w_sum_b >>> 15);
        end
    end

    assign o_valid    = r_v2;
    assign o_ab.alpha = r2_alpha;
    assign o_ab.beta  = r2_beta;

endmodule

[design/svpd_svm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_svm
// Sector search, active and zero vector times, saturated phase duties.
// ----------------------------------------------------------------------------
module svpd_svm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  svpd_pkg::t_ab   i_ab,
    output logic            o_valid,
    input  logic            i_ready,
    output svpd_pkg::t_duty o_duty
);

    import svpd_pkg::*;

    localparam int NS = 6;

    logic [NS-1:0] r_v;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || i_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            w_en[i] = !r_v[i] || w_en[i+1];
        end
    end

    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (w_en[i]) begin
                    r_v[i] <= r_v[i-1];
                end
            end
        end
    end

    // stage 1: sqrt3 * |alpha| against |beta|
    logic [17:0]        w_aabs;
    logic [17:0]        w_babs;
    logic [34:0]        r1_prod;
    logic [17:0]        r1_babs;
    logic signed [18:0] r1_alpha;
    logic signed [18:0] r1_beta;

    assign w_aabs = i_ab.alpha[18] ? 18'(-i_ab.alpha) : 18'(i_ab.alpha);
    assign w_babs = i_ab.beta[18]  ? 18'(-i_ab.beta)  : 18'(i_ab.beta);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_prod  <= 35'(w_aabs) * 35'(SQRT3_Q16);
            r1_babs  <= w_babs;
            r1_alpha <= i_ab.alpha;
            r1_beta  <= i_ab.beta;
        end
    end

    // stage 2: sector
    logic               w_steep;
    logic               w_apos;
    logic               w_bpos;
    logic [2:0]         w_k;
    logic [2:0]         r2_sec;
    logic signed [18:0] r2_alpha;
    logic signed [18:0] r2_beta;

    assign w_steep = {1'b0, r1_babs, 16'd0} > r1_prod;
    assign w_apos  = !r1_alpha[18] && (r1_alpha != '0);
    assign w_bpos  = !r1_beta[18] && (r1_beta != '0);
    assign w_k     = {w_bpos, w_steep, w_apos};

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_sec   <= SECTOR_OF_K[w_k];
            r2_alpha <= r1_alpha;
            r2_beta  <= r1_beta;
        end
    end

    // stage 3: products with the sector edge vectors
    logic [2:0]         w_prev;
    logic signed [36:0] r3_sa;
    logic signed [36:0] r3_cb;
    logic signed [36:0] r3_cpb;
    logic signed [36:0] r3_spa;
    logic [2:0]         r3_sec;

    assign w_prev = r2_sec - 3'd1;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_sa  <= SIN60K[r2_sec] * r2_alpha;
            r3_cb  <= COS60K[r2_sec] * r2_beta;
            r3_cpb <= COS60K[w_prev] * r2_beta;
            r3_spa <= SIN60K[w_prev] * r2_alpha;
            r3_sec <= r2_sec;
        end
    end

    // stage 4: active vector times
    logic signed [37:0] w_tm_sum;
    logic signed [37:0] w_tn_sum;
    logic signed [19:0] r4_tm;
    logic signed [19:0] r4_tn;
    logic [2:0]         r4_sec;

    assign w_tm_sum = 38'(r3_sa) - 38'(r3_cb) + 38'sd32768;
    assign w_tn_sum = 38'(r3_cpb) - 38'(r3_spa) + 38'sd32768;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_tm  <= 20'(w_tm_sum >>> 16);
            r4_tn  <= 20'(w_tn_sum >>> 16);
            r4_sec <= r3_sec;
        end
    end

    // stage 5: half of the zero vector time
    logic signed [20:0] w_t0;
    logic signed [20:0] w_t0_rnd;
    logic signed [19:0] r5_half0;
    logic signed [19:0] r5_tm;
    logic signed [19:0] r5_tn;
    logic [2:0]         r5_sec;

    assign w_t0     = 21'sd65536 - 21'(r4_tm) - 21'(r4_tn);
    assign w_t0_rnd = w_t0 + 21'sd1;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_half0 <= 20'(w_t0_rnd >>> 1);
            r5_tm    <= r4_tm;
            r5_tn    <= r4_tn;
            r5_sec   <= r4_sec;
        end
    end

    // stage 6: phase duties from the switching vectors, saturated
    logic [2:0]         w_vec_m;
    logic [2:0]         w_vec_n;
    logic [2:0]         w_next;
    logic signed [21:0] w_sum [3];
    logic [2:0][15:0]   w_duty;
    logic [2:0][15:0]   r6_duty;
    logic [2:0]         r6_sec;

    assign w_next  = (r5_sec == 3'd6) ? 3'd0 : r5_sec;
    assign w_vec_m = SWITCH_VEC[r5_sec - 3'd1];
    assign w_vec_n = SWITCH_VEC[w_next];

    always_comb begin
        for (int ph = 0; ph < 3; ph++) begin
            w_sum[ph] = 22'(r5_half0)
                      + (w_vec_m[ph] ? 22'(r5_tm) : 22'sd0)
                      + (w_vec_n[ph] ? 22'(r5_tn) : 22'sd0);
            if (w_sum[ph] < 22'sd0) begin
                w_duty[ph] = '0;
            end else if (w_sum[ph] > 22'(DUTY_MAX_Q16)) begin
                w_duty[ph] = DUTY_MAX_Q16;
            end else begin
                w_duty[ph] = 16'(w_sum[ph]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_duty <= w_duty;
            r6_sec  <= r5_sec;
        end
    end

    assign o_valid       = r_v[NS-1];
    assign o_duty.duty   = r6_duty;
    assign o_duty.sector = r6_sec;

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duty.sector >= 3'd1 && o_duty.sector <= 3'd6))
        else $error("sector out of range");

    a_duty_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duty.duty[0] <= DUTY_MAX_Q16 && o_duty.duty[1] <= DUTY_MAX_Q16
                     && o_duty.duty[2] <= DUTY_MAX_Q16))
        else $error("duty above saturation limit");

endmodule

[design/svpd_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpd_scale
// Scale duties by the PWM period into compare counts; output register.
// ----------------------------------------------------------------------------
module svpd_scale (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  svpd_pkg::t_duty i_duty,
    input  logic [15:0]     i_period,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_compare_u,
    output logic [15:0]     o_compare_v,
    output logic [15:0]     o_compare_w,
    output logic [2:0]      o_sector_num
);

    import svpd_pkg::*;

    logic w_en1;
    logic w_en2;
    logic r_v1;
    logic r_v2;

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    logic [2:0][31:0] r1_prod;
    logic [2:0]       r1_sec;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            for (int ph = 0; ph < 3; ph++) begin
                r1_prod[ph] <= 32'(i_duty.duty[ph]) * 32'(i_period);
            end
            r1_sec <= i_duty.sector;
        end
    end

    logic [2:0][15:0] w_cnt;
    logic [2:0][15:0] r2_cnt;
    logic [2:0]       r2_sec;

    always_comb begin
        for (int ph = 0; ph < 3; ph++) begin
            w_cnt[ph] = (r1_prod[ph][31:16] > COUNT_CAP) ? COUNT_CAP : r1_prod[ph][31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_cnt <= w_cnt;
            r2_sec <= r1_sec;
        end
    end

    assign o_valid      = r_v2;
    assign o_compare_u  = r2_cnt[0];
    assign o_compare_v  = r2_cnt[1];
    assign o_compare_w  = r2_cnt[2];
    assign o_sector_num = r2_sec;

endmodule
